/* rtl/core/bovl_pkg.sv */
// ----------------------------------------------------------------------------
// bovl_pkg
// Shared types and constants for the bounded ordered value list.
// ----------------------------------------------------------------------------
`default_nettype none

package bovl_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [1:0]                status;
    logic                      last;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_READ
  } op_t;

  // Decoded command as it waits in the queue between front and back.
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_word_t;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic valid;
  } q_status_t;

  typedef struct packed {
    logic pop;
  } q_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bounded_ordered_value_list.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_value_list
// Ordered list of signed 32-bit values with add, remove, clear and read out.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH values in a single-port-read RAM, head first.
// Commands enter a two-word queue, so up to two words are taken while the
// back end is busy; the back end works on one command at a time. Add and
// clear are handled in the idle state. Remove walks the RAM one entry per
// cycle: it searches from the head, moves each entry after the match one
// place toward the head, and then gives the response. Read out gives one
// result word per cycle per entry after one dispatch cycle. The RAM's single
// read port sets these figures. A result waits in an output register while
// the next command is already being taken. A stall on out_ready holds the
// back end, and once the queue holds two words it also holds off the input.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_value_list
  import bovl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  q_status_t q_status;
  cmd_word_t q_word;
  q_ctrl_t   q_ctrl;

  bovl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_word   (q_word),
    .q_ctrl   (q_ctrl)
  );

  bovl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_word    (q_word),
    .q_ctrl    (q_ctrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/core/bovl_ram.sv */
// ----------------------------------------------------------------------------
// bovl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bovl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/bovl_front.sv */
// ----------------------------------------------------------------------------
// bovl_front
// Accepts input words, decodes the command and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module bovl_front
  import bovl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output q_status_t      q_status,
  output cmd_word_t      q_word,
  input  wire q_ctrl_t   q_ctrl
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_word_t        q_mem_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   q_cnt_r, q_cnt_nxt;
  cmd_word_t        dec_word;
  logic             push;
  logic             pop;

  always_comb begin
    dec_word.value = in_data.value;
    case (in_data.cmd)
      CMD_ADD:    dec_word.op = OP_ADD;
      CMD_REMOVE: dec_word.op = OP_REMOVE;
      CMD_CLEAR:  dec_word.op = OP_CLEAR;
      CMD_READ:   dec_word.op = OP_READ;
      default:    dec_word.op = OP_READ;
    endcase
  end

  assign in_ready       = (q_cnt_r != QCW'(QUEUE_DEPTH));
  assign push           = in_valid && in_ready;
  assign pop            = q_ctrl.pop && (q_cnt_r != '0);
  assign q_status.valid = (q_cnt_r != '0);
  assign q_word         = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + QCW'(1);
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_word;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bovl_back.sv */
// ----------------------------------------------------------------------------
// bovl_back
// Executes queued commands against the entry store and drives the result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bovl_back
  import bovl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire cmd_word_t q_word,
  output q_ctrl_t        q_ctrl,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CXW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [1:0]                resp_r, resp_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_data_r, out_data_nxt;

  logic                      we;
  logic [AW-1:0]             wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  logic [AW-1:0]             rd_addr;
  logic [VALUE_W-1:0]        rd_data;

  logic                      slot_free;
  logic                      emit;
  out_word_t                 emit_word;
  logic                      is_last;
  logic                      shift_done;
  logic                      is_full;

  bovl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign is_last    = ((CXW'(idx_r) + CXW'(1)) == CXW'(count_r));
  assign shift_done = ((CXW'(idx_r) + CXW'(2)) == CXW'(count_r));
  assign is_full    = (count_r == CW'(DEPTH));

  // The read address always runs one step ahead, so in the search, shift and
  // read states the RAM output already holds the entry that idx_r points at
  // (or the one after it while shifting).
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    val_nxt         = val_r;
    resp_nxt        = resp_r;
    q_ctrl.pop      = 1'b0;
    we              = 1'b0;
    wr_addr         = idx_r;
    wr_data         = rd_data;
    rd_addr         = idx_r;
    emit            = 1'b0;
    emit_word       = '0;
    emit_word.last  = 1'b1;

    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        idx_nxt = '0;
        if (q_status.valid) begin
          case (q_word.op)
            OP_ADD: begin
              if (slot_free) begin
                q_ctrl.pop = 1'b1;
                emit       = 1'b1;
                if (is_full) begin
                  emit_word.status = ST_FULL;
                end else begin
                  emit_word.status = ST_OK;
                  we               = 1'b1;
                  wr_addr          = count_r[AW-1:0];
                  wr_data          = q_word.value;
                  count_nxt        = count_r + CW'(1);
                end
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                if (slot_free) begin
                  q_ctrl.pop       = 1'b1;
                  emit             = 1'b1;
                  emit_word.status = ST_NOT_FOUND;
                end
              end else begin
                q_ctrl.pop = 1'b1;
                val_nxt    = q_word.value;
                state_nxt  = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              if (slot_free) begin
                q_ctrl.pop       = 1'b1;
                emit             = 1'b1;
                emit_word.status = ST_OK;
                count_nxt        = '0;
              end
            end
            OP_READ: begin
              if (count_r == '0) begin
                if (slot_free) begin
                  q_ctrl.pop       = 1'b1;
                  emit             = 1'b1;
                  emit_word.status = ST_EMPTY;
                end
              end else begin
                q_ctrl.pop = 1'b1;
                state_nxt  = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        if (rd_data == val_r) begin
          if (is_last) begin
            count_nxt = count_r - CW'(1);
            resp_nxt  = ST_OK;
            state_nxt = S_RESP;
          end else begin
            rd_addr   = idx_r + AW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (is_last) begin
          resp_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1);
        end
      end

      S_SHIFT: begin
        // Move the entry after idx_r one place toward the head.
        we      = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        idx_nxt = idx_r + AW'(1);
        if (shift_done) begin
          count_nxt = count_r - CW'(1);
          resp_nxt  = ST_OK;
          state_nxt = S_RESP;
        end else begin
          rd_addr = idx_r + AW'(2);
        end
      end

      S_READ: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_word.item_value = rd_data;
          emit_word.status     = ST_OK;
          emit_word.last       = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_addr = idx_r + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_word.status = resp_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_word;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    resp_r     <= resp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
